// ===== hdl/edh_pkg.sv =====
// ----------------------------------------------------------------------------
// edh_pkg: shared types and constants of the equi-depth histogram builder
// Field widths, configuration register codes, record codes and the saturating
// counter helpers used by the step logic.
// ----------------------------------------------------------------------------
package edh_pkg;

	localparam int KEY_W   = 64;
	localparam int COUNT_W = 32;
	localparam int EXP_W   = 32;
	localparam int PCT_W   = 7;
	localparam int CFG_W   = EXP_W;

	localparam int PCT_SCALE = 100;

	// wide enough for count*100+99, percent product and count sums
	localparam int WIDE_W = ((COUNT_W > EXP_W) ? COUNT_W : EXP_W) + PCT_W + 1;
	localparam int PROD_W = EXP_W + PCT_W;

	localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(1);
	localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(50);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam logic KIND_BUCKET  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int MAX_RES = 3;

	typedef enum logic [0:0] {
		CFG_EXPECT  = 1'b0,
		CFG_PERCENT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             func;
		logic             key_is_null;
		logic [KEY_W-1:0] key;
	} key_word_t;

	typedef struct packed {
		logic               kind;
		logic [KEY_W-1:0]   first_key;
		logic [KEY_W-1:0]   final_key;
		logic [COUNT_W-1:0] bucket_distinct;
		logic [COUNT_W-1:0] bucket_rows;
		logic [COUNT_W-1:0] total_distinct;
		logic [COUNT_W-1:0] null_rows;
		logic               last;
	} rec_word_t;

	typedef struct packed {
		logic [1:0]                 n;
		rec_word_t [MAX_RES-1:0]    res;
	} push_t;

	typedef struct packed {
		logic [KEY_W-1:0]   pend_key;
		logic [COUNT_W-1:0] pend_cnt;
		logic               open;
		logic [KEY_W-1:0]   open_first;
		logic [KEY_W-1:0]   open_final;
		logic [COUNT_W-1:0] open_dist;
		logic [COUNT_W-1:0] open_rows;
		logic [COUNT_W-1:0] dist_total;
		logic [COUNT_W-1:0] null_total;
	} hist_state_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
		return (a == {COUNT_W{1'b1}}) ? a : a + COUNT_W'(1);
	endfunction

	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
	                                               input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
	endfunction

endpackage

// ===== hdl/edh_step.sv =====
// ----------------------------------------------------------------------------
// edh_step: input register, histogram state and per-word update
// Holds the pending run, the open bucket and stream totals; each fired word
// updates them and hands up to three records to the queue.
// ----------------------------------------------------------------------------
module edh_step (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr,
	input  edh_pkg::cfg_idx_t       cfg_idx,
	input  logic [edh_pkg::CFG_W-1:0] cfg_data,
	input  logic                    key_valid,
	output logic                    key_stall,
	input  edh_pkg::key_word_t      key_word,
	input  logic                    room,
	output logic                    push_valid,
	output edh_pkg::push_t          push
);

	logic [edh_pkg::EXP_W-1:0]  expect_q;
	logic [edh_pkg::PCT_W-1:0]  pct_q;
	logic [edh_pkg::PROD_W-1:0] prod_q;

	logic               valid_s1;
	edh_pkg::key_word_t word_s1;
	logic               fire;

	edh_pkg::hist_state_t st_q;
	edh_pkg::hist_state_t nxt;

	logic [edh_pkg::WIDE_W-1:0] cnt_sc;
	logic [edh_pkg::WIDE_W-1:0] rows_sc;
	logic [edh_pkg::WIDE_W-1:0] run_sum;
	logic                       split;
	logic                       fv_do;
	edh_pkg::rec_word_t         rec_a;
	edh_pkg::rec_word_t         rec_b;
	edh_pkg::rec_word_t         rec_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= edh_pkg::EXP_RESET;
			pct_q    <= edh_pkg::PCT_RESET;
			prod_q   <= edh_pkg::PROD_W'(edh_pkg::EXP_RESET) *
			            edh_pkg::PROD_W'(edh_pkg::PCT_RESET);
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					edh_pkg::CFG_EXPECT:  expect_q <= cfg_data[edh_pkg::EXP_W-1:0];
					edh_pkg::CFG_PERCENT: pct_q    <= cfg_data[edh_pkg::PCT_W-1:0];
					default:              ;
				endcase
			end
			prod_q <= edh_pkg::PROD_W'(expect_q) * edh_pkg::PROD_W'(pct_q);
		end
	end

	assign fire      = valid_s1 && room;
	assign key_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_valid && !key_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (key_valid && !key_stall) begin
			word_s1 <= key_word;
		end
	end

	// cnt >= floor(prod/100)  <=>  cnt*100 + 99 >= prod
	assign cnt_sc  = edh_pkg::WIDE_W'(st_q.pend_cnt) * edh_pkg::WIDE_W'(edh_pkg::PCT_SCALE)
	               + edh_pkg::WIDE_W'(edh_pkg::PCT_SCALE - 1);
	assign rows_sc = edh_pkg::WIDE_W'(st_q.open_rows) * edh_pkg::WIDE_W'(edh_pkg::PCT_SCALE)
	               + edh_pkg::WIDE_W'(edh_pkg::PCT_SCALE - 1);
	assign run_sum = edh_pkg::WIDE_W'(st_q.pend_cnt) + edh_pkg::WIDE_W'(st_q.open_rows);
	assign split   = st_q.open && (cnt_sc >= edh_pkg::WIDE_W'(prod_q)
	                 || rows_sc >= edh_pkg::WIDE_W'(prod_q)
	                 || run_sum >= edh_pkg::WIDE_W'(expect_q));

	always_comb begin
		nxt   = st_q;
		fv_do = 1'b0;
		rec_a = '0;
		rec_b = '0;
		rec_c = '0;
		push  = '0;

		rec_a.kind            = edh_pkg::KIND_BUCKET;
		rec_a.first_key       = st_q.open_first;
		rec_a.final_key       = st_q.open_final;
		rec_a.bucket_distinct = st_q.open_dist;
		rec_a.bucket_rows     = st_q.open_rows;

		if (word_s1.func == edh_pkg::FUNC_INSERT) begin
			if (word_s1.key_is_null) begin
				nxt.null_total = edh_pkg::sat_inc(st_q.null_total);
			end else if (st_q.pend_cnt == '0) begin
				nxt.pend_key = word_s1.key;
				nxt.pend_cnt = edh_pkg::COUNT_W'(1);
			end else if (word_s1.key == st_q.pend_key) begin
				nxt.pend_cnt = edh_pkg::sat_inc(st_q.pend_cnt);
			end else if (word_s1.key > st_q.pend_key) begin
				fv_do = 1'b1;
			end
		end else begin
			fv_do = (st_q.pend_cnt != '0);
		end

		// close the pending run into the open bucket or a new one
		if (fv_do) begin
			nxt.dist_total = edh_pkg::sat_inc(st_q.dist_total);
			if (!st_q.open || split) begin
				nxt.open       = 1'b1;
				nxt.open_first = st_q.pend_key;
				nxt.open_final = st_q.pend_key;
				nxt.open_dist  = edh_pkg::COUNT_W'(1);
				nxt.open_rows  = st_q.pend_cnt;
			end else begin
				nxt.open_final = st_q.pend_key;
				nxt.open_dist  = edh_pkg::sat_inc(st_q.open_dist);
				nxt.open_rows  = edh_pkg::sat_add(st_q.open_rows, st_q.pend_cnt);
			end
		end

		if (word_s1.func == edh_pkg::FUNC_INSERT) begin
			if (fv_do) begin
				nxt.pend_key = word_s1.key;
				nxt.pend_cnt = edh_pkg::COUNT_W'(1);
			end
			rec_a.last  = 1'b1;
			push.res[0] = rec_a;
			push.n      = {1'b0, fv_do && split};
		end else begin
			rec_b.kind            = edh_pkg::KIND_BUCKET;
			rec_b.first_key       = nxt.open_first;
			rec_b.final_key       = nxt.open_final;
			rec_b.bucket_distinct = nxt.open_dist;
			rec_b.bucket_rows     = nxt.open_rows;
			rec_c.kind            = edh_pkg::KIND_SUMMARY;
			rec_c.total_distinct  = nxt.dist_total;
			rec_c.null_rows       = nxt.null_total;
			rec_c.last            = 1'b1;
			if (fv_do && split) begin
				push.res[0] = rec_a;
				push.res[1] = rec_b;
				push.res[2] = rec_c;
				push.n      = 2'd3;
			end else if (nxt.open) begin
				push.res[0] = rec_b;
				push.res[1] = rec_c;
				push.n      = 2'd2;
			end else begin
				push.res[0] = rec_c;
				push.n      = 2'd1;
			end
			nxt = '0;
		end
	end

	assign push_valid = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= nxt;
		end
	end

endmodule

// ===== hdl/edh_outq.sv =====
// ----------------------------------------------------------------------------
// edh_outq: record queue toward the output channel
// Shift queue of four records; takes up to three records a cycle while it
// signals room, and presents the head record as the output word.
// ----------------------------------------------------------------------------
module edh_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  edh_pkg::push_t     push,
	output logic               room,
	output logic               rec_valid,
	input  logic               rec_stall,
	output edh_pkg::rec_word_t rec_word
);

	edh_pkg::rec_word_t [edh_pkg::QDEPTH-1:0] q_q;
	edh_pkg::rec_word_t [edh_pkg::QDEPTH-1:0] q_nxt;
	logic [edh_pkg::QCNT_W-1:0] count_q;
	logic [edh_pkg::QCNT_W-1:0] base;
	logic [edh_pkg::QCNT_W-1:0] n_in;
	logic                       pop;

	assign pop       = (count_q != '0) && !rec_stall;
	assign base      = count_q - edh_pkg::QCNT_W'(pop);
	assign n_in      = push_valid ? edh_pkg::QCNT_W'(push.n) : '0;
	assign room      = (count_q <= edh_pkg::QCNT_W'(edh_pkg::QDEPTH - edh_pkg::MAX_RES));
	assign rec_valid = (count_q != '0);
	assign rec_word  = q_q[0];

	always_comb begin
		logic [edh_pkg::QCNT_W-1:0] off;
		for (int i = 0; i < edh_pkg::QDEPTH; i++) begin
			off = edh_pkg::QCNT_W'(i) - base;
			q_nxt[i] = q_q[i];
			if (edh_pkg::QCNT_W'(i) < base) begin
				if (pop && i < edh_pkg::QDEPTH - 1) begin
					q_nxt[i] = q_q[(i < edh_pkg::QDEPTH - 1) ? i + 1 : i];
				end
			end else if (off < n_in) begin
				q_nxt[i] = push.res[off[1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + n_in;
		end
	end

endmodule

// ===== hdl/equi_depth_histogram_builder_top.sv =====
// ----------------------------------------------------------------------------
// equi_depth_histogram_builder_top: equi-depth histogram over a sorted stream
// Run-length counts sorted keys into buckets and emits bucket and summary
// records.
// ----------------------------------------------------------------------------
// Usage:
//   Key channel (key_valid/key_stall/key_word): one word per row, or a finish
//   word that flushes the pending key, the last bucket and a summary record.
//   Record channel (rec_valid/rec_stall/rec_word): bucket records, then the
//   summary on finish; last marks the final record caused by a word.
//   Config port: cfg_wr with cfg_idx/cfg_data sets the target bucket size and
//   split percent; write only while the block is idle.
//   A taken key word waits in the step stage until the record queue has room.
//   Throughput: one key word per cycle while the queue has room; the state
//   update is done in the step stage. A finish word makes up to three
//   records, which the four-entry record queue drains one per cycle while the
//   receiver does not stall, holding off new words meanwhile.
//   Reset clears all histogram state, empties the queue and restores the
//   target size to one and the split percent to fifty.
//   A stalled receiver holds the head record; once the queue has more than
//   one record waiting, key_stall rises while a key word is held in the step stage.
// ----------------------------------------------------------------------------
module equi_depth_histogram_builder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr,
	input  edh_pkg::cfg_idx_t         cfg_idx,
	input  logic [edh_pkg::CFG_W-1:0] cfg_data,
	input  logic                      key_valid,
	output logic                      key_stall,
	input  edh_pkg::key_word_t        key_word,
	output logic                      rec_valid,
	input  logic                      rec_stall,
	output edh_pkg::rec_word_t        rec_word
);

	logic           room;
	logic           push_valid;
	edh_pkg::push_t push;

	edh_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key_word   (key_word),
		.room       (room),
		.push_valid (push_valid),
		.push       (push)
	);

	edh_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push       (push),
		.room       (room),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_word   (rec_word)
	);

endmodule

// ===== hdl/edh_checker.sv =====
// ----------------------------------------------------------------------------
// edh_checker: port-level checks of the histogram builder
// Watches the record channel for hold behavior and record consistency.
// ----------------------------------------------------------------------------
module edh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rec_valid,
	input logic               rec_stall,
	input edh_pkg::rec_word_t rec_word
);

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(rec_word))
		else $error("record word changed while stalled");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_word.kind == edh_pkg::KIND_SUMMARY |->
			rec_word.last && rec_word.bucket_distinct == '0 && rec_word.bucket_rows == '0)
		else $error("summary record malformed");

	a_bucket_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_word.kind == edh_pkg::KIND_BUCKET |->
			rec_word.bucket_distinct != '0 && rec_word.first_key <= rec_word.final_key
			&& rec_word.total_distinct == '0 && rec_word.null_rows == '0)
		else $error("bucket record malformed");

	a_bucket_rows: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_word.kind == edh_pkg::KIND_BUCKET |->
			rec_word.bucket_rows >= rec_word.bucket_distinct)
		else $error("bucket holds fewer rows than keys");

endmodule

bind equi_depth_histogram_builder_top edh_checker u_edh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (rec_valid),
	.rec_stall (rec_stall),
	.rec_word  (rec_word)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: regression bench for equi_depth_histogram_builder_top
// Drives sorted key runs with nulls, repeats, descending noise and finish
// words under several bucket-size and split-percent settings. Every taken
// word runs through a local histogram predictor, and every record taken is
// compared field by field against the oldest predicted record. Sender bursts
// and receiver stalls vary, including one long receiver hold.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT = 200000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_wr = 1'b0;
	edh_pkg::cfg_idx_t         cfg_idx = edh_pkg::CFG_EXPECT;
	logic [edh_pkg::CFG_W-1:0] cfg_data = '0;
	logic                      key_valid = 1'b0;
	logic                      key_stall;
	edh_pkg::key_word_t        key_word = '0;
	logic                      rec_valid;
	logic                      rec_stall = 1'b0;
	edh_pkg::rec_word_t        rec_word;

	equi_depth_histogram_builder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.key_valid(key_valid),
		.key_stall(key_stall),
		.key_word (key_word),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec_word (rec_word)
	);

	always #6 clk = ~clk;

	edh_pkg::key_word_t key_backlog[$];
	edh_pkg::rec_word_t expected_recs[$];

	// predictor copy of configuration and histogram state
	logic [edh_pkg::EXP_W-1:0]   size_target = edh_pkg::EXP_RESET;
	logic [edh_pkg::PCT_W-1:0]   split_pct = edh_pkg::PCT_RESET;
	logic [edh_pkg::KEY_W-1:0]   h_pend_key = '0;
	logic [edh_pkg::COUNT_W-1:0] h_pend_cnt = '0;
	logic                        h_open = 1'b0;
	logic [edh_pkg::KEY_W-1:0]   h_first = '0;
	logic [edh_pkg::KEY_W-1:0]   h_final = '0;
	logic [edh_pkg::COUNT_W-1:0] h_dist = '0;
	logic [edh_pkg::COUNT_W-1:0] h_rows = '0;
	logic [edh_pkg::COUNT_W-1:0] h_dist_total = '0;
	logic [edh_pkg::COUNT_W-1:0] h_nulls = '0;

	int cycle_count = 0;
	int mismatches = 0;
	int words_taken = 0;
	int recs_checked = 0;
	int cfg_writes = 0;
	bit word_taken = 0;
	int burst_left = 8;
	int gap_left = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int rx_cycle = 0;

	function automatic logic [edh_pkg::COUNT_W-1:0] cnt_add(
			input logic [edh_pkg::COUNT_W-1:0] a,
			input logic [edh_pkg::COUNT_W-1:0] b);
		return (a > ~b) ? {edh_pkg::COUNT_W{1'b1}} : a + b;
	endfunction

	task automatic emit_bucket(input logic last_rec);
		edh_pkg::rec_word_t r;
		r = '0;
		r.kind = edh_pkg::KIND_BUCKET;
		r.first_key = h_first;
		r.final_key = h_final;
		r.bucket_distinct = h_dist;
		r.bucket_rows = h_rows;
		r.last = last_rec;
		expected_recs.insert(expected_recs.size(), r);
	endtask

	task automatic start_bucket(input logic [edh_pkg::KEY_W-1:0] k,
	                            input logic [edh_pkg::COUNT_W-1:0] c);
		h_open = 1'b1;
		h_first = k;
		h_final = k;
		h_dist = 1;
		h_rows = c;
	endtask

	task automatic close_value(input logic [edh_pkg::KEY_W-1:0] k,
	                           input logic [edh_pkg::COUNT_W-1:0] c,
	                           input logic last_rec);
		logic [39:0] thr;
		logic split;
		h_dist_total = cnt_add(h_dist_total, 1);
		if (!h_open) begin
			start_bucket(k, c);
		end else begin
			thr = (40'(size_target) * 40'(split_pct)) / 40'(edh_pkg::PCT_SCALE);
			split = (40'(c) >= thr) || (40'(h_rows) >= thr) ||
			        (({1'b0, c} + {1'b0, h_rows}) >= {1'b0, size_target});
			if (split) begin
				emit_bucket(last_rec);
				start_bucket(k, c);
			end else begin
				h_dist = cnt_add(h_dist, 1);
				h_rows = cnt_add(h_rows, c);
				h_final = k;
			end
		end
	endtask

	task automatic hist_predict(input edh_pkg::key_word_t w);
		edh_pkg::rec_word_t r;
		if (w.func == edh_pkg::FUNC_INSERT) begin
			if (w.key_is_null) begin
				h_nulls = cnt_add(h_nulls, 1);
			end else if (h_pend_cnt == 0) begin
				h_pend_key = w.key;
				h_pend_cnt = 1;
			end else if (w.key == h_pend_key) begin
				h_pend_cnt = cnt_add(h_pend_cnt, 1);
			end else if (w.key > h_pend_key) begin
				close_value(h_pend_key, h_pend_cnt, 1'b1);
				h_pend_key = w.key;
				h_pend_cnt = 1;
			end
		end else begin
			if (h_pend_cnt != 0)
				close_value(h_pend_key, h_pend_cnt, 1'b0);
			if (h_open)
				emit_bucket(1'b0);
			r = '0;
			r.kind = edh_pkg::KIND_SUMMARY;
			r.total_distinct = h_dist_total;
			r.null_rows = h_nulls;
			r.last = 1'b1;
			expected_recs.insert(expected_recs.size(), r);
			h_pend_key = '0;
			h_pend_cnt = '0;
			h_open = 1'b0;
			h_first = '0;
			h_final = '0;
			h_dist = '0;
			h_rows = '0;
			h_dist_total = '0;
			h_nulls = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatches++;
		end
	endtask

	// sample side: config mirror, prediction on taken words, record checks
	always @(posedge clk) begin
		edh_pkg::rec_word_t want;
		cycle_count++;
		if (arst_n) begin
			if (cfg_wr) begin
				cfg_writes++;
				case (cfg_idx)
					edh_pkg::CFG_EXPECT: size_target = cfg_data[edh_pkg::EXP_W-1:0];
					edh_pkg::CFG_PERCENT: split_pct = cfg_data[edh_pkg::PCT_W-1:0];
					default: ;
				endcase
			end
			if (key_valid && !key_stall) begin
				hist_predict(key_word);
				key_backlog.delete(0);
				word_taken = 1;
				words_taken++;
			end
			if (rec_valid && !rec_stall) begin
				if (expected_recs.size() == 0) begin
					$error("record with no expectation: %h", rec_word);
					mismatches++;
				end else begin
					want = expected_recs.pop_front();
					check_field("kind", 64'(want.kind), 64'(rec_word.kind));
					check_field("first_key", want.first_key, rec_word.first_key);
					check_field("final_key", want.final_key, rec_word.final_key);
					check_field("bucket_distinct", 64'(want.bucket_distinct),
					            64'(rec_word.bucket_distinct));
					check_field("bucket_rows", 64'(want.bucket_rows),
					            64'(rec_word.bucket_rows));
					check_field("total_distinct", 64'(want.total_distinct),
					            64'(rec_word.total_distinct));
					check_field("null_rows", 64'(want.null_rows),
					            64'(rec_word.null_rows));
					check_field("last", 64'(want.last), 64'(rec_word.last));
					recs_checked++;
				end
			end
		end
	end

	// key driver: bursts of words with random gaps
	always @(negedge clk) begin
		logic               nv;
		edh_pkg::key_word_t nw;
		if (arst_n) begin
			nv = key_valid;
			nw = key_word;
			if (word_taken) begin
				word_taken = 0;
				nv = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (key_backlog.size() > 0) begin
					nv = 1'b1;
					nw = key_backlog[0];
				end
			end
			key_valid <= nv;
			key_word <= nw;
		end
	end

	// record receiver: rotating stall pattern, plus a long hold on request
	always @(negedge clk) begin
		logic ns;
		if (arst_n) begin
			rx_cycle++;
			if (hold_req) begin
				hold_req = 0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: ns = 1'b0;
					1: ns = ($urandom_range(0, 2) == 0);
					2: ns = ($urandom_range(0, 3) != 0);
					default: ns = ((rx_cycle % 5) < 2);
				endcase
			end
			rec_stall <= ns;
		end
	end

	initial begin
		while (cycle_count < LIMIT)
			@(posedge clk);
		$display("equi_depth_histogram_builder_top regression: fail");
		$finish;
	end

	task automatic queue_word(input logic f, input logic n,
	                          input logic [edh_pkg::KEY_W-1:0] k);
		edh_pkg::key_word_t w;
		w.func = f;
		w.key_is_null = n;
		w.key = k;
		key_backlog.insert(key_backlog.size(), w);
	endtask

	// sorted run with repeats, nulls, descending noise and stray finishes
	task automatic queue_run(input int n);
		logic [edh_pkg::KEY_W-1:0] k;
		int r;
		case ($urandom_range(0, 2))
			0: k = {$urandom, $urandom};
			1: k = edh_pkg::KEY_W'($urandom_range(0, 3));
			default: k = {32'hffff_ffff, 24'hff_ffff, 8'($urandom)};
		endcase
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				queue_word(edh_pkg::FUNC_FINISH, 1'($urandom), {$urandom, $urandom});
			end else if (r < 12) begin
				queue_word(edh_pkg::FUNC_INSERT, 1'b1, {$urandom, $urandom});
			end else if (r < 18) begin
				queue_word(edh_pkg::FUNC_INSERT, 1'b0,
				           (k > 16) ? k - edh_pkg::KEY_W'($urandom_range(1, 9)) : k);
			end else if (r < 55) begin
				queue_word(edh_pkg::FUNC_INSERT, 1'b0, k);
			end else begin
				k = k + edh_pkg::KEY_W'($urandom_range(1, 3));
				queue_word(edh_pkg::FUNC_INSERT, 1'b0, k);
			end
		end
		queue_word(edh_pkg::FUNC_FINISH, 1'($urandom), {$urandom, $urandom});
	endtask

	task automatic wait_idle();
		while (key_backlog.size() != 0 || key_valid || expected_recs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(input edh_pkg::cfg_idx_t idx,
	                         input logic [edh_pkg::CFG_W-1:0] d);
		@(negedge clk);
		cfg_wr <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic run_setting(input logic [edh_pkg::CFG_W-1:0] sz,
	                           input logic [edh_pkg::CFG_W-1:0] pct, input int n);
		write_cfg(edh_pkg::CFG_EXPECT, sz);
		write_cfg(edh_pkg::CFG_PERCENT, pct);
		queue_run(n);
		wait_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: every finished value splits
		queue_word(edh_pkg::FUNC_FINISH, 1'b0, '0);
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, '0);
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, '0);
		queue_word(edh_pkg::FUNC_INSERT, 1'b1, {edh_pkg::KEY_W{1'b1}});
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(7));
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(3));
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(7));
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, {edh_pkg::KEY_W{1'b1}});
		queue_word(edh_pkg::FUNC_FINISH, 1'b1, {$urandom, $urandom});
		wait_idle();

		// target 10 at full percent: joins until the sum reaches the target
		write_cfg(edh_pkg::CFG_EXPECT, 10);
		write_cfg(edh_pkg::CFG_PERCENT, 100);
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(1));
		repeat (2) queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(2));
		repeat (3) queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(3));
		repeat (5) queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(4));
		queue_word(edh_pkg::FUNC_INSERT, 1'b0, edh_pkg::KEY_W'(9));
		queue_word(edh_pkg::FUNC_FINISH, 1'b0, {edh_pkg::KEY_W{1'b1}});
		wait_idle();

		run_setting(0, 127, 12);
		run_setting(32'hffff_ffff, 100, 12);
		run_setting(32'hffff_ffff, 0, 12);

		// long receiver hold while the sender keeps offering words
		write_cfg(edh_pkg::CFG_EXPECT, 2);
		write_cfg(edh_pkg::CFG_PERCENT, 50);
		@(posedge clk);
		hold_req = 1;
		queue_run(24);
		wait_idle();

		repeat (3)
			run_setting($urandom_range(1, 12), $urandom_range(0, 100), 8);

		repeat (10) @(negedge clk);
		$display("covered %0d key words, %0d records and %0d register writes,",
		         words_taken, recs_checked, cfg_writes);
		$display("with zero, unit and full-scale targets and one long receiver hold");
		if (mismatches == 0)
			$display("equi_depth_histogram_builder_top regression: pass");
		else
			$display("equi_depth_histogram_builder_top regression: fail");
		$finish;
	end

endmodule
